// File: hdl/siq_pkg.sv
// shared types and constants for the sorted insert queue
package siq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int ID_BITS_DEF   = 8;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SORTED     = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic insert;      // an entry goes in this cycle
    logic remove;      // head leaves, all cells move down one place
    logic push_front;  // insert position is the head
    logic push_back;   // insert position is the first free cell
  } cell_ctl_t;

endpackage

// File: hdl/siq_cell.sv
// one queue cell: holds an entry and trades it with its neighbors
module siq_cell import siq_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic                 occupied,
  input  logic [TIME_BITS-1:0] new_time,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TIME_BITS-1:0] left_time,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [TIME_BITS-1:0] right_time,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic                 found_in,
  output logic [TIME_BITS-1:0] cell_time,
  output logic [ID_BITS-1:0]   cell_id,
  output logic                 found_out
);

  logic hit;

  // this cell is a candidate insert position
  always_comb begin
    priority if (ctl.push_front) begin
      hit = 1'b1;
    end else if (ctl.push_back) begin
      hit = !occupied;
    end else begin
      hit = !occupied || (cell_time >= new_time);
    end
  end

  // position found here or in some cell closer to the head
  assign found_out = found_in || hit;

  // shift up behind the insert point, take the new entry at it, shift down on pop
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (found_in) begin
        cell_time <= left_time;
        cell_id   <= left_id;
      end else if (hit) begin
        cell_time <= new_time;
        cell_id   <= new_id;
      end
    end else if (ctl.remove) begin
      cell_time <= right_time;
      cell_id   <= right_id;
    end
  end

endmodule

// File: hdl/sorted_insert_queue_top.sv
// top level of the sorted insert queue: command decode, count and cell row
//
// A bounded queue of (start time, process id) entries held in a row of cells,
// head in the first cell. Commands arrive on start with kind, start_time and
// process_id; a command transfers at a rising edge with start high and busy
// low. busy stays low: every cell compares its key against the new one in
// parallel and the first matching cell is found through a neighbor-to-neighbor
// chain, so one command is taken every cycle.
// Kinds: sorted insert (before the first entry with an equal or larger time,
// else at the tail), push front, push back, pop front, pop back.
// Each command gives one result in the next cycle, shown for exactly one cycle
// with done high: head entry after the command, the entry count and a status
// (done, rejected because full, pop ignored because empty). The receiver
// cannot stall; a result must be taken in the cycle it is shown.
// Throughput is one command per cycle, set by the
// insert-position chain across the cells.
// Reset empties the queue and clears done; cell contents are not cleared.
module sorted_insert_queue_top import siq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_BITS-1:0]   kind,
  input  logic [TIME_BITS-1:0]   start_time,
  input  logic [ID_BITS-1:0]     process_id,
  output logic                   done,
  output logic                   head_valid,
  output logic [TIME_BITS-1:0]   head_time,
  output logic [ID_BITS-1:0]     head_process,
  output logic [COUNT_BITS-1:0]  entry_count,
  output logic [STATUS_BITS-1:0] status
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  status_t               status_q;
  status_t               status_next;
  cell_ctl_t             ctl;
  logic                  accept;
  logic                  full;
  logic                  empty;

  logic [TIME_BITS-1:0]  cell_time [DEPTH];
  logic [ID_BITS-1:0]    cell_id   [DEPTH];
  logic                  found     [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_BITS'(DEPTH));
  assign empty  = (count == '0);

  // command decode
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = STATUS_DONE;
    if (accept) begin
      unique case (kind_t'(kind))
        KIND_SORTED, KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            ctl.insert     = 1'b1;
            ctl.push_front = (kind_t'(kind) == KIND_PUSH_FRONT);
            ctl.push_back  = (kind_t'(kind) == KIND_PUSH_BACK);
            count_next     = count + 1'b1;
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            ctl.remove = (kind_t'(kind) == KIND_POP_FRONT);
            count_next = count - 1'b1;
          end
        end
        default: begin
          status_next = STATUS_DONE;
        end
      endcase
    end
  end

  // count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result status, loaded per transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 found_in;
    logic [TIME_BITS-1:0] left_time;
    logic [ID_BITS-1:0]   left_id;
    logic [TIME_BITS-1:0] right_time;
    logic [ID_BITS-1:0]   right_id;

    if (i == 0) begin : g_first
      assign found_in  = 1'b0;
      assign left_time = start_time;
      assign left_id   = process_id;
    end else begin : g_inner
      assign found_in  = found[i-1];
      assign left_time = cell_time[i-1];
      assign left_id   = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_time = cell_time[i];
      assign right_id   = cell_id[i];
    end else begin : g_mid
      assign right_time = cell_time[i+1];
      assign right_id   = cell_id[i+1];
    end

    siq_cell #(
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (COUNT_BITS'(i) < count),
      .new_time   (start_time),
      .new_id     (process_id),
      .left_time  (left_time),
      .left_id    (left_id),
      .right_time (right_time),
      .right_id   (right_id),
      .found_in   (found_in),
      .cell_time  (cell_time[i]),
      .cell_id    (cell_id[i]),
      .found_out  (found[i])
    );
  end

  // result fields: head entry from the head cell, count and status
  assign head_valid   = !empty;
  assign head_time    = empty ? '0 : cell_time[0];
  assign head_process = empty ? '0 : cell_id[0];
  assign entry_count  = count;
  assign status       = status_q;

endmodule
